[sv/tpcd_pkg.sv]
`timescale 1ns / 1ps

package tpcd_pkg;

  // Bins per frame; the position counter saturates at the top bin.
  localparam int BIN_COUNT = 1024;
  localparam int BIN_W     = $clog2(BIN_COUNT);
  localparam int IDX_W     = 10;
  localparam int CMP_W     = (BIN_W > IDX_W) ? BIN_W : IDX_W;
  localparam int MAG_W     = 32;
  localparam int SPD_W     = 11;
  localparam int OUT_SPD_W = 12;

  localparam logic [SPD_W-1:0] SPEED_LIMIT = 11'd1100;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PEAK_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_MIN_BIN         = 3'd1;
  localparam logic [2:0] REG_MAX_BIN         = 3'd2;
  localparam logic [2:0] REG_FORWARD_CENTER  = 3'd3;
  localparam logic [2:0] REG_LEFT_CENTER     = 3'd4;
  localparam logic [2:0] REG_RIGHT_CENTER    = 3'd5;
  localparam logic [2:0] REG_BACKWARD_CENTER = 3'd6;
  localparam logic [2:0] REG_DRIVE_SPEED     = 3'd7;

  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_LEFT     = 3'd2,
    CMD_RIGHT    = 3'd3,
    CMD_BACKWARD = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } peak_t;

  typedef struct packed {
    logic [IDX_W-1:0] forward_center;
    logic [IDX_W-1:0] left_center;
    logic [IDX_W-1:0] right_center;
    logic [IDX_W-1:0] backward_center;
    logic [SPD_W-1:0] drive_speed;
  } band_cfg_t;

  typedef struct packed {
    logic signed [OUT_SPD_W-1:0] left_speed;
    logic signed [OUT_SPD_W-1:0] right_speed;
    cmd_t                        command;
    logic [IDX_W-1:0]            peak_bin;
    logic                        peak_found;
  } result_t;

endpackage

[sv/tpcd_cmd_map.sv]
`timescale 1ns / 1ps

// Maps a frame's peak to a wheel command: band match, then speed signs.
module tpcd_cmd_map import tpcd_pkg::*; (
  input  peak_t     peak,
  input  band_cfg_t bands,
  output result_t   result
);

  function automatic logic in_band(input logic [IDX_W-1:0] idx,
                                   input logic [IDX_W-1:0] centre);
    logic [IDX_W:0] idx_x;
    logic [IDX_W:0] cen_x;
    begin
      idx_x = {1'b0, idx};
      cen_x = {1'b0, centre};
      in_band = ((idx_x + 1'b1) >= cen_x) && (idx_x <= (cen_x + 1'b1));
    end
  endfunction

  cmd_t                  cmd;
  logic [SPD_W-1:0]      speed_lim;
  logic [OUT_SPD_W-1:0]  spd_pos;
  logic [OUT_SPD_W-1:0]  spd_neg;

  always_comb begin
    cmd = CMD_STOP;
    if (peak.valid) begin
      if (in_band(peak.index, bands.forward_center)) begin
        cmd = CMD_FORWARD;
      end else if (in_band(peak.index, bands.left_center)) begin
        cmd = CMD_LEFT;
      end else if (in_band(peak.index, bands.right_center)) begin
        cmd = CMD_RIGHT;
      end else if (in_band(peak.index, bands.backward_center)) begin
        cmd = CMD_BACKWARD;
      end
    end
  end

  assign speed_lim = (bands.drive_speed > SPEED_LIMIT) ? SPEED_LIMIT : bands.drive_speed;
  assign spd_pos   = {1'b0, speed_lim};
  assign spd_neg   = OUT_SPD_W'(0) - spd_pos;

  always_comb begin
    result.command    = cmd;
    result.peak_bin   = peak.valid ? peak.index : '0;
    result.peak_found = peak.valid;
    unique case (cmd)
      CMD_FORWARD: begin
        result.left_speed  = spd_pos;
        result.right_speed = spd_pos;
      end
      CMD_LEFT: begin
        result.left_speed  = spd_neg;
        result.right_speed = spd_pos;
      end
      CMD_RIGHT: begin
        result.left_speed  = spd_pos;
        result.right_speed = spd_neg;
      end
      CMD_BACKWARD: begin
        result.left_speed  = spd_neg;
        result.right_speed = spd_neg;
      end
      default: begin
        result.left_speed  = '0;
        result.right_speed = '0;
      end
    endcase
  end

endmodule

[sv/tone_peak_command_decoder.sv]
`timescale 1ns / 1ps
// Latency: a result appears in the cycle after its last-bin item is accepted.
// Throughput: one bin item per cycle when not stalled; the peak compare and
// the band decode sit between the tracking registers and the result register.
// in_ready drops only while a finished command waits and out_ready is low.
// Reset (rst_n low, synchronous): registers to defaults, frame position 0,
// no peak held, result register empty.
module tone_peak_command_decoder import tpcd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // bin stream
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MAG_W-1:0]            in_magnitude,
  input  logic                        in_last_bin,
  // command out
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_SPD_W-1:0] out_left_speed,
  output logic signed [OUT_SPD_W-1:0] out_right_speed,
  output logic [2:0]                  out_command,
  output logic [IDX_W-1:0]            out_peak_bin,
  output logic                        out_peak_found,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  // ---------------- configuration registers ----------------
  logic [MAG_W-1:0] thr_r;
  logic [IDX_W-1:0] min_bin_r;
  logic [IDX_W-1:0] max_bin_r;
  band_cfg_t        bands_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r                   <= 32'd10000;
      min_bin_r               <= 10'd10;
      max_bin_r               <= 10'd30;
      bands_r.forward_center  <= 10'd16;
      bands_r.left_center     <= 10'd19;
      bands_r.right_center    <= 10'd23;
      bands_r.backward_center <= 10'd26;
      bands_r.drive_speed     <= 11'd600;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PEAK_THRESHOLD:  thr_r                   <= cfg_data;
        REG_MIN_BIN:         min_bin_r               <= cfg_data[IDX_W-1:0];
        REG_MAX_BIN:         max_bin_r               <= cfg_data[IDX_W-1:0];
        REG_FORWARD_CENTER:  bands_r.forward_center  <= cfg_data[IDX_W-1:0];
        REG_LEFT_CENTER:     bands_r.left_center     <= cfg_data[IDX_W-1:0];
        REG_RIGHT_CENTER:    bands_r.right_center    <= cfg_data[IDX_W-1:0];
        REG_BACKWARD_CENTER: bands_r.backward_center <= cfg_data[IDX_W-1:0];
        REG_DRIVE_SPEED:     bands_r.drive_speed     <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_r;
  logic in_fire;

  // A held command only blocks when nobody is taking it this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------- peak tracking ----------------
  localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(BIN_COUNT - 1);

  logic [BIN_W-1:0] bin_pos_r, bin_pos_nxt;
  logic [MAG_W-1:0] peak_val_r, peak_val_nxt;
  peak_t            peak_r, peak_nxt;

  logic [MAG_W-1:0] cur_val;
  peak_t            cur_peak;
  logic [CMP_W-1:0] pos_x;
  logic             in_range;

  // First bin of a frame starts from the threshold as it stands now.
  assign cur_val  = (bin_pos_r == '0) ? thr_r : peak_val_r;
  assign cur_peak = (bin_pos_r == '0) ? peak_t'('0) : peak_r;

  assign pos_x    = CMP_W'(bin_pos_r);
  assign in_range = (pos_x >= CMP_W'(min_bin_r)) && (pos_x <= CMP_W'(max_bin_r));

  always_comb begin
    peak_val_nxt = cur_val;
    peak_nxt     = cur_peak;
    // Strict compare keeps the first of equal maxima.
    if (in_range && (in_magnitude > cur_val)) begin
      peak_val_nxt   = in_magnitude;
      peak_nxt.valid = 1'b1;
      peak_nxt.index = IDX_W'(pos_x);
    end
    if (in_last_bin) begin
      bin_pos_nxt = '0;
    end else if (bin_pos_r != BIN_MAX) begin
      bin_pos_nxt = bin_pos_r + 1'b1;
    end else begin
      bin_pos_nxt = bin_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_pos_r <= '0;
      peak_r    <= '0;
    end else if (in_fire) begin
      bin_pos_r <= bin_pos_nxt;
      peak_r    <= peak_nxt;
    end
  end

  // Payload only; reloaded from the threshold at frame start.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      peak_val_r <= peak_val_nxt;
    end
  end

  // ---------------- command decode and result register ----------------
  result_t res_comb;
  result_t res_r;

  tpcd_cmd_map u_cmd_map (
    .peak   (peak_nxt),
    .bands  (bands_r),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_bin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_bin) begin
      res_r <= res_comb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_speed  = res_r.left_speed;
  assign out_right_speed = res_r.right_speed;
  assign out_command     = res_r.command;
  assign out_peak_bin    = res_r.peak_bin;
  assign out_peak_found  = res_r.peak_found;

  // ---------------- checks ----------------
  // peak_r may still hold the old frame's peak; position 0 masks it on the next bin.
  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_bin |=> out_valid_r && (bin_pos_r == '0))
    else $error("last bin did not post a result and restart the frame");

  a_stop_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.command == CMD_STOP) |->
      (res_r.left_speed == '0) && (res_r.right_speed == '0))
    else $error("stop command with nonzero wheel speed");

  a_no_peak_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.peak_found |->
      (res_r.command == CMD_STOP) && (res_r.peak_bin == '0))
    else $error("motion command without a peak");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_last_bin && (bin_pos_r == BIN_MAX) |=> bin_pos_r == BIN_MAX)
    else $error("bin position wrapped past the top bin");

endmodule

[tb/steer_command_checker.sv]
`timescale 1ns / 1ps

module steer_command_checker import tpcd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [MAG_W-1:0]            in_magnitude,
  input  logic                        in_last_bin,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [OUT_SPD_W-1:0] out_left_speed,
  input  logic signed [OUT_SPD_W-1:0] out_right_speed,
  input  logic [2:0]                  out_command,
  input  logic [IDX_W-1:0]            out_peak_bin,
  input  logic                        out_peak_found,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          commands_seen
);

  // shadow registers
  logic [MAG_W-1:0] threshold;
  logic [IDX_W-1:0] lo_bin;
  logic [IDX_W-1:0] hi_bin;
  band_cfg_t        bands;

  // peak search state
  int               bin_pos;
  logic [MAG_W-1:0] best_mag;
  logic [IDX_W-1:0] best_bin;
  logic             best_ok;

  result_t          cmd_queue[$];
  int               errors;
  int               commands;

  // band is centre-1 .. centre+1, clipped at zero
  function automatic bit near(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] centre);
    return (int'(idx) + 1 >= int'(centre)) && (int'(idx) <= int'(centre) + 1);
  endfunction

  task automatic take_reg_write(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_PEAK_THRESHOLD:  threshold = data;
      REG_MIN_BIN:         lo_bin = data[IDX_W-1:0];
      REG_MAX_BIN:         hi_bin = data[IDX_W-1:0];
      REG_FORWARD_CENTER:  bands.forward_center = data[IDX_W-1:0];
      REG_LEFT_CENTER:     bands.left_center = data[IDX_W-1:0];
      REG_RIGHT_CENTER:    bands.right_center = data[IDX_W-1:0];
      REG_BACKWARD_CENTER: bands.backward_center = data[IDX_W-1:0];
      REG_DRIVE_SPEED:     bands.drive_speed = data[SPD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic track_bin(input logic [MAG_W-1:0] mag, input logic last);
    result_t          r;
    logic [SPD_W-1:0] spd;
    if (bin_pos == 0) begin
      best_mag = threshold;
      best_bin = '0;
      best_ok  = 1'b0;
    end
    if (bin_pos >= lo_bin && bin_pos <= hi_bin && mag > best_mag) begin
      best_mag = mag;
      best_bin = IDX_W'(bin_pos);
      best_ok  = 1'b1;
    end
    if (bin_pos < BIN_COUNT - 1) bin_pos++;
    if (last) begin
      r.command = CMD_STOP;
      if (best_ok) begin
        if (near(best_bin, bands.forward_center)) r.command = CMD_FORWARD;
        else if (near(best_bin, bands.left_center)) r.command = CMD_LEFT;
        else if (near(best_bin, bands.right_center)) r.command = CMD_RIGHT;
        else if (near(best_bin, bands.backward_center)) r.command = CMD_BACKWARD;
      end
      spd = (bands.drive_speed > SPEED_LIMIT) ? SPEED_LIMIT : bands.drive_speed;
      if (r.command == CMD_STOP) spd = '0;
      r.left_speed  = (r.command inside {CMD_LEFT, CMD_BACKWARD}) ?
                      -$signed({1'b0, spd}) : $signed({1'b0, spd});
      r.right_speed = (r.command inside {CMD_RIGHT, CMD_BACKWARD}) ?
                      -$signed({1'b0, spd}) : $signed({1'b0, spd});
      r.peak_bin   = best_ok ? best_bin : '0;
      r.peak_found = best_ok;
      cmd_queue.push_back(r);
      bin_pos = 0;
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("t=%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      threshold = 32'd10000;
      lo_bin    = 10'd10;
      hi_bin    = 10'd30;
      bands.forward_center  = 10'd16;
      bands.left_center     = 10'd19;
      bands.right_center    = 10'd23;
      bands.backward_center = 10'd26;
      bands.drive_speed     = 11'd600;
      bin_pos  = 0;
      best_mag = threshold;
      best_bin = '0;
      best_ok  = 1'b0;
      cmd_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) take_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) track_bin(in_magnitude, in_last_bin);
      if (out_valid && out_ready) begin
        commands++;
        if (cmd_queue.size() == 0) begin
          errors++;
          $display("t=%0t: command out with none expected, expected nothing, got cmd %0d bin %0d",
                   $time, out_command, out_peak_bin);
        end else begin
          want = cmd_queue.pop_front();
          check_field("left_speed", want.left_speed, out_left_speed);
          check_field("right_speed", want.right_speed, out_right_speed);
          check_field("command", int'(want.command), out_command);
          check_field("peak_bin", want.peak_bin, out_peak_bin);
          check_field("peak_found", want.peak_found, out_peak_found);
        end
      end
    end
    // published with NBAs so the stimulus side samples a settled value
    fail_count    <= errors;
    pending       <= cmd_queue.size();
    commands_seen <= commands;
  end

  initial begin
    errors   = 0;
    commands = 0;
  end

endmodule

[tb/tb_tone_peak_command_decoder.sv]
`timescale 1ns / 1ps

module tb_tone_peak_command_decoder;
  import tpcd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1200;
  // output-side back-pressure burst, long enough to fill the block
  localparam int HOLD_CYCLES  = 400;

  typedef logic [MAG_W-1:0] mag_list_t[$];

  // one full register image
  typedef struct {
    logic [MAG_W-1:0] threshold;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] fwd;
    logic [IDX_W-1:0] lft;
    logic [IDX_W-1:0] rgt;
    logic [IDX_W-1:0] bck;
    logic [SPD_W-1:0] speed;
  } reg_set_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [MAG_W-1:0]            in_magnitude;
  logic                        in_last_bin;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [OUT_SPD_W-1:0] out_left_speed;
  logic signed [OUT_SPD_W-1:0] out_right_speed;
  logic [2:0]                  out_command;
  logic [IDX_W-1:0]            out_peak_bin;
  logic                        out_peak_found;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [2:0]                  cfg_index;
  logic [31:0]                 cfg_data;

  int       fail_count;
  int       pending;
  int       commands_seen;
  int       cycles = 0;
  int       items_sent = 0;
  int       settings_loaded = 0;
  bit       gaps_on = 1'b1;
  reg_set_t cur;

  tone_peak_command_decoder DUT (.*);

  steer_command_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still owed", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Command sink: random stalls, one long hold once the stream is well under way,
  // and no random stalls while the stimulus side turns gaps off.
  initial begin : sink_proc
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && commands_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (gaps_on) begin
        out_ready <= ($urandom_range(0, 99) >= 11);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic reg_set_t make_setting(input logic [MAG_W-1:0] thr,
                                            input int lo, input int hi, input int fwd,
                                            input int lft, input int rgt, input int bck,
                                            input int speed);
    reg_set_t s;
    s.threshold = thr;
    s.lo    = IDX_W'(lo);
    s.hi    = IDX_W'(hi);
    s.fwd   = IDX_W'(fwd);
    s.lft   = IDX_W'(lft);
    s.rgt   = IDX_W'(rgt);
    s.bck   = IDX_W'(bck);
    s.speed = SPD_W'(speed);
    return s;
  endfunction

  // centre somewhere around the search window, now and then at an edge
  function automatic logic [IDX_W-1:0] pick_centre(input reg_set_t s);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return s.lo + IDX_W'($urandom_range(0, (s.hi >= s.lo) ? s.hi - s.lo + 2 : 4));
    endcase
  endfunction

  function automatic reg_set_t random_setting();
    reg_set_t s;
    case ($urandom_range(0, 9))
      0: s.threshold = '0;
      1: s.threshold = '1;
      2: s.threshold = $urandom;
      default: s.threshold = $urandom_range(0, 100000);
    endcase
    s.lo = IDX_W'($urandom_range(0, 12));
    s.hi = s.lo + IDX_W'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0: s.hi = s.lo - IDX_W'($urandom_range(1, 3));   // inverted, none searched, unless hi wraps
      1: begin
        s.lo = '0;
        s.hi = '1;
      end
      default: ;
    endcase
    s.fwd = pick_centre(s);
    s.lft = pick_centre(s);
    s.rgt = pick_centre(s);
    s.bck = pick_centre(s);
    case ($urandom_range(0, 7))
      0: s.speed = '0;
      1: s.speed = SPEED_LIMIT;
      2: s.speed = SPD_W'(SPEED_LIMIT + 1);
      3: s.speed = '1;
      default: s.speed = SPD_W'($urandom_range(0, 2047));
    endcase
    return s;
  endfunction

  // magnitudes clustered around the threshold so peaks, ties and misses all happen
  function automatic logic [MAG_W-1:0] pick_mag(input logic [MAG_W-1:0] thr);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return thr;
      3: return (thr == '1) ? thr : thr + 1;
      4, 5, 6: return (thr > 32'hFFFF_0000) ? $urandom : thr + $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // one bin item; valid is only dropped while idling, never toggled within a step
  task automatic push_bin(input logic [MAG_W-1:0] mag, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_magnitude <= mag;
    in_last_bin  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_frame(input mag_list_t mags);
    foreach (mags[i]) push_bin(mags[i], i == mags.size() - 1);
  endtask

  task automatic push_random_frame(input int len);
    for (int i = 0; i < len; i++) push_bin(pick_mag(cur.threshold), i == len - 1);
  endtask

  // stop offering, let every owed command drain, then let the outputs settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // narrow registers get random junk in the unused upper data bits
  task automatic load_setting(input reg_set_t s);
    send_reg(REG_PEAK_THRESHOLD, s.threshold);
    send_reg(REG_MIN_BIN, {22'($urandom), s.lo});
    send_reg(REG_MAX_BIN, {22'($urandom), s.hi});
    send_reg(REG_FORWARD_CENTER, {22'($urandom), s.fwd});
    send_reg(REG_LEFT_CENTER, {22'($urandom), s.lft});
    send_reg(REG_RIGHT_CENTER, {22'($urandom), s.rgt});
    send_reg(REG_BACKWARD_CENTER, {22'($urandom), s.bck});
    send_reg(REG_DRIVE_SPEED, {21'($urandom), s.speed});
    cfg_valid <= 1'b0;
    cur = s;
    settings_loaded++;
  endtask

  initial begin : stimulus
    int phase;
    int target;
    int len;
    int frames;
    in_valid     <= 1'b0;
    in_magnitude <= '0;
    in_last_bin  <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_PEAK_THRESHOLD;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: bins 0 and 1 sit below the default window -> stop
    push_frame('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain(4);

    // overlapping bands at the low edge, speed above the clamp
    load_setting(make_setting(32'd100, 0, 7, 0, 1, 2, 3, 2047));
    push_frame('{32'hFFFF_FFFF});                       // single-bin frame, forward
    push_frame('{32'd50, 32'd100, 32'd200, 32'd200});   // equal-to-threshold ignored, first max wins
    push_frame('{32'd0, 32'd0, 32'd0, 32'd300});        // right
    push_frame('{32'd0, 32'd0, 32'd0, 32'd0, 32'd300}); // backward
    push_frame('{32'd0, 32'd100});                      // nothing above threshold
    drain(4);

    // min above max: nothing searched
    load_setting(make_setting(32'd0, 3, 1, 0, 0, 0, 0, 0));
    push_frame('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain(4);

    // peak found outside every band; centre 0 reaches bins 0 and 1 only
    load_setting(make_setting(32'd0, 0, 1023, 0, 1023, 1023, 1023, 1100));
    push_frame('{32'd0, 32'd0, 32'd5});
    drain(4);

    // random phases: each one a register image plus a run of frames
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      case (phase)
        0: load_setting(make_setting('1, 0, 1023, 1023, 1023, 1023, 1023, 2047));
        1: load_setting(make_setting('0, 0, 0, 0, 0, 0, 0, 0));
        2: load_setting(make_setting($urandom_range(0, 1000), 1000 + $urandom_range(0, 23),
                                     1023, 1023, 1021, 1019, 0, $urandom_range(0, 1100)));
        default: load_setting(random_setting());
      endcase
      gaps_on = (phase != 3);
      if (phase == 2) begin
        // past the top bin the index saturates and later bins still compete
        len = BIN_COUNT + $urandom_range(0, 40);
        target += len;
        push_random_frame(len);
      end
      frames = $urandom_range(8, 20);
      repeat (frames) begin
        len = (cur.hi + 4 > 60) ? 60 : cur.hi + 4;
        push_random_frame($urandom_range(1, len));
      end
      drain(4);
      phase++;
    end
    gaps_on = 1'b1;

    drain(10);
    $display("%0d bin items in %0d register settings, %0d commands checked,", items_sent,
             settings_loaded, commands_seen);
    $display("including a frame past the top bin and a %0d-cycle output hold", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
